// ===== rtl/texture_mip_layout_checker_assert.svh =====
// Assertion macros shared by the checker RTL.
`ifndef TEXTURE_MIP_LAYOUT_CHECKER_ASSERT_SVH
`define TEXTURE_MIP_LAYOUT_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMLC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("texture_mip_layout_checker: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define TMLC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("texture_mip_layout_checker: property violated");

`endif

// ===== rtl/tmlc_pkg.sv =====
package tmlc_pkg;

	localparam int FIELD_DIM_W = 16;
	localparam int LEVEL_W     = 5;
	localparam int TOTAL_W     = 31;
	localparam int LIMIT_W     = 9;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

	typedef enum logic [1:0] {
		MAP_2D    = 2'd0,
		MAP_CUBE  = 2'd1,
		MAP_3D    = 2'd2,
		MAP_OTHER = 2'd3
	} map_t;

	localparam logic [1:0] MFLAG_NONE   = 2'd0;
	localparam logic [1:0] MFLAG_CUBE   = 2'd1;
	localparam logic [1:0] MFLAG_VOLUME = 2'd2;

	localparam logic [3:0] FMT_DXT1      = 4'd0;
	localparam logic [3:0] FMT_DXT5      = 4'd2;
	localparam logic [3:0] FMT_RGBA_LAST = 4'd7;
	localparam logic [3:0] FMT_HALF_LAST = 4'd9;
	localparam logic [3:0] FMT_BYTE_LAST = 4'd11;

	typedef struct packed {
		logic       supported;
		logic       block;
		logic [2:0] shift;
	} fmt_info_t;

	function automatic fmt_info_t fmt_decode(logic [3:0] fmt);
		fmt_info_t fi;
		fi = '{supported: 1'b1, block: 1'b0, shift: 3'd0};
		priority if (fmt == FMT_DXT1) begin
			fi.block = 1'b1;
			fi.shift = 3'd3;
		end else if (fmt <= FMT_DXT5) begin
			fi.block = 1'b1;
			fi.shift = 3'd4;
		end else if (fmt <= FMT_RGBA_LAST) begin
			fi.shift = 3'd2;
		end else if (fmt <= FMT_HALF_LAST) begin
			fi.shift = 3'd1;
		end else if (fmt <= FMT_BYTE_LAST) begin
			fi.shift = 3'd0;
		end else begin
			fi.supported = 1'b0;
		end
		return fi;
	endfunction

	// Number of doublings from one needed to reach v, for v of at least one.
	function automatic logic [LEVEL_W-1:0] ceil_log2(logic [FIELD_DIM_W-1:0] v);
		logic [FIELD_DIM_W-1:0] m;
		logic [LEVEL_W-1:0]     r;
		m = v - 1'b1;
		r = '0;
		for (int i = 0; i < FIELD_DIM_W; i++) begin
			if (m[i]) begin
				r = LEVEL_W'(i + 1);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/texture_mip_layout_checker.sv =====
// Channel   Handshake                  Payload
// in        in_valid / in_ready        track_index .. resource_size
// out       out_valid / out_ready      layout_ok, total_bytes, mip_levels
// cfg       cfg_valid / cfg_ready      track_limit
//
// An item is checked in S_CHECK, then each mip level passes S_MUL1, S_MUL2 and S_ACCUM
// on the shared 32x16 multiplier (two products and one accumulate), then S_CLOSE closes
// the total. S_DONE loads the result into the output register once that register is free;
// an early reject goes from S_CHECK straight to S_DONE. One item is in work at a time; the
// next is accepted once the result is loaded into the output register, even while that
// result waits for out_ready. Reset is asynchronous and active low; it sets track_limit to 256.
`include "texture_mip_layout_checker_assert.svh"

module texture_mip_layout_checker #(
	parameter int DIM_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tmlc_pkg::LIMIT_W-1:0]       track_limit,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         track_index,
	input  logic [tmlc_pkg::FIELD_DIM_W-1:0]   image_width,
	input  logic [tmlc_pkg::FIELD_DIM_W-1:0]   image_height,
	input  logic [tmlc_pkg::FIELD_DIM_W-1:0]   image_depth,
	input  logic signed [31:0]                 load_width,
	input  logic signed [31:0]                 load_height,
	input  logic signed [31:0]                 load_depth,
	input  logic [3:0]                         image_kind,
	input  logic [2:0]                         load_flags,
	input  logic [7:0]                         declared_levels,
	input  logic [3:0]                         pixel_format,
	input  logic signed [31:0]                 resource_size,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               layout_ok,
	output logic [tmlc_pkg::TOTAL_W-1:0]       total_bytes,
	output logic [tmlc_pkg::LEVEL_W-1:0]       mip_levels
);

	import tmlc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHECK = 7'b0000010,
		S_MUL1  = 7'b0000100,
		S_MUL2  = 7'b0001000,
		S_ACCUM = 7'b0010000,
		S_CLOSE = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	localparam int DW = FIELD_DIM_W;

	state_t                st_q;
	logic [LIMIT_W-1:0]    track_limit_q;

	logic [7:0]            ti_q;
	logic [DW-1:0]         w_q, h_q, d_q;
	logic [31:0]           lw_q, lh_q, ld_q;
	logic [3:0]            kind_q;
	logic [2:0]            flags_q;
	logic [7:0]            declared_q;
	logic [3:0]            fmt_q;
	logic [31:0]           rsize_q;

	logic [DW-1:0]         mw_q, mh_q, md_q;
	logic                  block_q;
	logic [2:0]            shift_q;
	logic [LEVEL_W-1:0]    lv_q;
	logic [LEVEL_W-1:0]    levels_q;
	logic [TOTAL_W-1:0]    total_q;
	logic                  res_ok_q;
	logic [31:0]           prod_q;
	logic [47:0]           term_q;

	logic                  out_valid_q;
	logic                  layout_ok_q;
	logic [TOTAL_W-1:0]    total_bytes_q;
	logic [LEVEL_W-1:0]    mip_levels_q;

	map_t                  map;
	logic [1:0]            mflags;
	logic                  early_bad;
	logic                  map_bad;
	logic [DW-1:0]         maxd;
	logic [LEVEL_W-1:0]    levels_calc;
	logic                  decl_bad;
	fmt_info_t             fi;

	logic [DW-1:0]         mw_e, mh_e, md_e, bw, bh;
	logic [31:0]           mul_a;
	logic [DW-1:0]         mul_b;
	logic [47:0]           mul_p;
	logic [51:0]           term_sh;
	logic [52:0]           acc_sum;
	logic                  acc_over;
	logic [33:0]           final_total;
	logic                  final_over;
	logic                  size_ok;
	logic                  in_acc;
	logic                  out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign layout_ok   = layout_ok_q;
	assign total_bytes = total_bytes_q;
	assign mip_levels  = mip_levels_q;

	// Descriptor checks and level count, all from the captured item.
	always_comb begin
		map    = map_t'(kind_q[1:0]);
		mflags = flags_q[1:0];
		early_bad = !kind_q[2] || ({1'b0, ti_q} >= track_limit_q) || rsize_q[31] ||
			lw_q[31] || (lw_q == '0) || lh_q[31] || (lh_q == '0) ||
			ld_q[31] || (ld_q == '0) ||
			(lw_q != 32'(w_q)) || (lh_q != 32'(h_q)) || (ld_q != 32'(d_q));
		unique case (map)
			MAP_2D:   map_bad = (mflags != MFLAG_NONE) || (d_q != DW'(1));
			MAP_CUBE: map_bad = (mflags != MFLAG_CUBE) || (w_q != h_q) || (d_q != DW'(1));
			MAP_3D:   map_bad = (mflags != MFLAG_VOLUME);
			default:  map_bad = 1'b1;
		endcase
		maxd = (w_q > h_q) ? w_q : h_q;
		if (d_q > maxd) begin
			maxd = d_q;
		end
		levels_calc = flags_q[2] ? LEVEL_W'(1) : LEVEL_W'(1) + ceil_log2(maxd);
		decl_bad    = (declared_q != '0) && (declared_q != 8'(levels_calc));
		fi          = fmt_decode(fmt_q);
	end

	// Shared multiplier: block or texel footprint first, then times the depth.
	always_comb begin
		mw_e = (mw_q == '0) ? DW'(1) : mw_q;
		mh_e = (mh_q == '0) ? DW'(1) : mh_q;
		md_e = (md_q == '0) ? DW'(1) : md_q;
		bw   = DW'((17'(mw_e) + 17'd3) >> 2);
		bh   = DW'((17'(mh_e) + 17'd3) >> 2);
		if (st_q == S_MUL2) begin
			mul_a = prod_q;
			mul_b = md_e;
		end else begin
			mul_a = block_q ? 32'(bw) : 32'(mw_e);
			mul_b = block_q ? bh : mh_e;
		end
		mul_p = 48'(mul_a) * 48'(mul_b);
	end

	always_comb begin
		term_sh  = 52'(term_q) << shift_q;
		acc_sum  = 53'(term_sh) + 53'(total_q);
		acc_over = acc_sum > 53'(TOTAL_MAX);
		final_total = (map == MAP_CUBE) ? ({3'b0, total_q} << 2) + ({3'b0, total_q} << 1)
			: 34'(total_q);
		final_over  = final_total > 34'(TOTAL_MAX);
		size_ok     = ((rsize_q == '0) && kind_q[3] && (map == MAP_2D)) ||
			(rsize_q == {1'b0, final_total[TOTAL_W-1:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			track_limit_q <= track_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((st_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						st_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (early_bad || map_bad || decl_bad || !fi.supported) begin
						st_q <= S_DONE;
					end else begin
						st_q <= S_MUL1;
					end
				end
				S_MUL1:  st_q <= S_MUL2;
				S_MUL2:  st_q <= S_ACCUM;
				S_ACCUM: begin
					if (acc_over) begin
						st_q <= S_DONE;
					end else if (lv_q == levels_q - 1'b1) begin
						st_q <= S_CLOSE;
					end else begin
						st_q <= S_MUL1;
					end
				end
				S_CLOSE: st_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ti_q       <= track_index;
			w_q        <= DW'(image_width[DIM_BITS-1:0]);
			h_q        <= DW'(image_height[DIM_BITS-1:0]);
			d_q        <= DW'(image_depth[DIM_BITS-1:0]);
			lw_q       <= load_width;
			lh_q       <= load_height;
			ld_q       <= load_depth;
			kind_q     <= image_kind;
			flags_q    <= load_flags;
			declared_q <= declared_levels;
			fmt_q      <= pixel_format;
			rsize_q    <= resource_size;
		end
		unique case (st_q)
			S_CHECK: begin
				res_ok_q <= 1'b0;
				total_q  <= '0;
				lv_q     <= '0;
				mw_q     <= w_q;
				mh_q     <= h_q;
				md_q     <= d_q;
				block_q  <= fi.block;
				shift_q  <= fi.shift;
				levels_q <= (early_bad || map_bad) ? '0 : levels_calc;
			end
			S_MUL1: prod_q <= mul_p[31:0];
			S_MUL2: term_q <= mul_p;
			S_ACCUM: begin
				if (acc_over) begin
					total_q <= TOTAL_MAX;
				end else begin
					total_q <= acc_sum[TOTAL_W-1:0];
				end
				lv_q <= lv_q + 1'b1;
				mw_q <= mw_q >> 1;
				mh_q <= mh_q >> 1;
				md_q <= md_q >> 1;
			end
			S_CLOSE: begin
				if (final_over) begin
					total_q <= TOTAL_MAX;
				end else begin
					total_q  <= final_total[TOTAL_W-1:0];
					res_ok_q <= size_ok;
				end
			end
			S_DONE: begin
				if (out_free) begin
					layout_ok_q   <= res_ok_q;
					total_bytes_q <= total_q;
					mip_levels_q  <= levels_q;
				end
			end
			default: begin
			end
		endcase
	end

	`TMLC_ASSERT_IMP(a_ok_has_levels, clk, arst_n, out_valid && layout_ok, mip_levels != '0)
	`TMLC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`TMLC_ASSERT_IMP(a_early_reject_zero, clk, arst_n, out_valid && (mip_levels == '0), !layout_ok && (total_bytes == '0))
	`TMLC_ASSERT_IMP(a_level_in_range, clk, arst_n, (st_q == S_MUL1) || (st_q == S_MUL2) || (st_q == S_ACCUM), lv_q < levels_q)

endmodule
